// ----- src/rtu_rx_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtu_rx_pkg
// Shared types, constants and the byte-wide CRC-16 update for the serial
// frame receive check.
// ----------------------------------------------------------------------------
package rtu_rx_pkg;

    // Frame limits and CRC constants
    localparam int unsigned MAX_FRAME_BYTES_DEF = 256;
    localparam logic [15:0] CRC_INIT            = 16'hFFFF;
    localparam logic [15:0] CRC_POLY            = 16'hA001;

    // Result queue depth (power of two)
    localparam int unsigned FIFO_DEPTH = 4;

    // Result item kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Length status codes
    localparam logic [1:0] LEN_OK    = 2'd0;
    localparam logic [1:0] LEN_SHORT = 2'd1;
    localparam logic [1:0] LEN_LONG  = 2'd2;

    // One result item
    typedef struct packed {
        logic       item_kind;
        logic [7:0] payload_byte;
        logic [7:0] station_address;
        logic [7:0] function_code;
        logic [7:0] payload_count;
        logic       crc_match;
        logic [1:0] length_status;
        logic       last_of_run;
    } t_item;

    // Fold one byte into a reflected CRC-16, LSB first
    function automatic logic [15:0] crc_feed(logic [15:0] crc_in, logic [7:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

// ----- src/rtu_frame_receive_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtu_frame_receive_check
// Receive-side frame check: strips address, function code and CRC, forwards
// the payload two bytes late and closes each frame with a summary item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) takes one received byte per transfer,
//   with i_end_of_frame set on the last byte of a frame. Output channel
//   (o_valid / i_ready) delivers result items: payload bytes (kind 0) and
//   one summary per frame (kind 1) carrying address, function code, payload
//   count, CRC match and length status. o_last_of_run marks the final item
//   caused by one input byte.
//   Results are registered in the queue before they are presented. Throughput:
//   one byte per cycle while o_ready is high. Frame state and the CRC update
//   are combinational per byte; results go through a 4-entry queue that
//   drains one item per cycle while i_ready is high, so the extra summary
//   item at end of frame is absorbed while the next frame's header bytes
//   produce no output. o_ready is high while the queue has room for two
//   items. Reset clears the frame state (CRC to 0xFFFF, position and held
//   bytes to zero) and empties the queue. When the receiver stalls, items
//   wait in the queue; once it holds more than two, input transfers pause.
// ----------------------------------------------------------------------------
module rtu_frame_receive_check #(
    parameter int unsigned MAX_FRAME_BYTES = rtu_rx_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte input
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_end_of_frame,
    // result output
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_item_kind,
    output logic [7:0] o_payload_byte,
    output logic [7:0] o_station_address,
    output logic [7:0] o_function_code,
    output logic [7:0] o_payload_count,
    output logic       o_crc_match,
    output logic [1:0] o_length_status,
    output logic       o_last_of_run
);

    localparam int unsigned PW      = $clog2(MAX_FRAME_BYTES + 2);
    localparam int unsigned DEPTH   = rtu_rx_pkg::FIFO_DEPTH;
    localparam int unsigned PTR_W   = $clog2(DEPTH);
    localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] POS_SAT = PW'(MAX_FRAME_BYTES + 1);
    localparam logic [PW-1:0] POS_MAX = PW'(MAX_FRAME_BYTES);
    localparam logic [7:0]    CNT_SAT = 8'(MAX_FRAME_BYTES - 4);

    // Frame state
    logic [15:0]   r_crc,  n_crc;
    logic [PW-1:0] r_pos,  n_pos;
    logic [7:0]    r_dly0, n_dly0;
    logic [7:0]    r_dly1, n_dly1;
    logic [7:0]    r_addr, n_addr;
    logic [7:0]    r_func, n_func;

    // Result queue
    rtu_rx_pkg::t_item r_fifo [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count,  n_count;

    logic              w_in_xfer, w_out_xfer;
    logic              w_pay, w_eof;
    logic [15:0]       w_crc;
    logic [PW:0]       w_len_raw;
    logic [PW-1:0]     w_len, w_len_m4;
    logic [7:0]        w_sum_addr, w_sum_func;
    rtu_rx_pkg::t_item w_pay_item, w_sum_item, w_slot0;
    logic              w_push0, w_push1;
    logic [1:0]        w_n_push;

    assign o_ready    = (r_count < CNT_W'(DEPTH - 1));
    assign o_valid    = (r_count != '0);
    assign w_in_xfer  = i_valid && o_ready;
    assign w_out_xfer = o_valid && i_ready;

    // Process one byte: CRC, delay line, position and summary fields
    always_comb begin
        w_eof      = i_end_of_frame;
        w_pay      = (r_pos >= PW'(4));
        w_crc      = (r_pos >= PW'(2)) ? rtu_rx_pkg::crc_feed(r_crc, r_dly0) : r_crc;
        w_len_raw  = {1'b0, r_pos} + (PW+1)'(1);
        w_len      = (w_len_raw > {1'b0, POS_SAT}) ? POS_SAT : w_len_raw[PW-1:0];
        w_len_m4   = w_len - PW'(4);
        w_sum_addr = (r_pos == '0) ? i_rx_byte : r_addr;
        w_sum_func = (r_pos == '0) ? 8'h00 :
                     (r_pos == PW'(1)) ? i_rx_byte : r_func;

        // payload item
        w_pay_item              = '0;
        w_pay_item.item_kind    = rtu_rx_pkg::KIND_PAYLOAD;
        w_pay_item.payload_byte = r_dly0;
        w_pay_item.last_of_run  = !w_eof;

        // summary item
        w_sum_item                 = '0;
        w_sum_item.item_kind       = rtu_rx_pkg::KIND_SUMMARY;
        w_sum_item.station_address = w_sum_addr;
        w_sum_item.function_code   = w_sum_func;
        w_sum_item.last_of_run     = 1'b1;
        if (w_len < PW'(4)) begin
            w_sum_item.length_status = rtu_rx_pkg::LEN_SHORT;
        end else begin
            w_sum_item.crc_match = ({i_rx_byte, r_dly1} == w_crc);
            if (w_len > POS_MAX) begin
                w_sum_item.length_status = rtu_rx_pkg::LEN_LONG;
                w_sum_item.payload_count = CNT_SAT;
            end else begin
                w_sum_item.length_status = rtu_rx_pkg::LEN_OK;
                w_sum_item.payload_count = 8'(w_len_m4);
            end
        end

        // next frame state; end of frame returns to the reset values
        if (w_eof) begin
            n_crc  = rtu_rx_pkg::CRC_INIT;
            n_pos  = '0;
            n_dly0 = 8'h00;
            n_dly1 = 8'h00;
            n_addr = 8'h00;
            n_func = 8'h00;
        end else begin
            n_crc  = w_crc;
            n_pos  = w_len;
            n_dly0 = r_dly1;
            n_dly1 = i_rx_byte;
            n_addr = w_sum_addr;
            n_func = w_sum_func;
        end
    end

    // Queue push selection and occupancy
    always_comb begin
        w_push0  = w_in_xfer && (w_pay || w_eof);
        w_push1  = w_in_xfer && w_pay && w_eof;
        w_slot0  = w_pay ? w_pay_item : w_sum_item;
        w_n_push = {1'b0, w_push0} + {1'b0, w_push1};
        n_count  = r_count + CNT_W'(w_n_push) - CNT_W'(w_out_xfer);
    end

    // Hold frame state and queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc    <= rtu_rx_pkg::CRC_INIT;
            r_pos    <= '0;
            r_dly0   <= 8'h00;
            r_dly1   <= 8'h00;
            r_addr   <= 8'h00;
            r_func   <= 8'h00;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_in_xfer) begin
                r_crc  <= n_crc;
                r_pos  <= n_pos;
                r_dly0 <= n_dly0;
                r_dly1 <= n_dly1;
                r_addr <= n_addr;
                r_func <= n_func;
            end
            r_wr_ptr <= r_wr_ptr + PTR_W'(w_n_push);
            if (w_out_xfer) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    // Write result items into the queue
    always_ff @(posedge i_clk) begin
        if (w_push0) begin
            r_fifo[r_wr_ptr] <= w_slot0;
        end
        if (w_push1) begin
            r_fifo[r_wr_ptr + PTR_W'(1)] <= w_sum_item;
        end
    end

    // Present the head of the queue
    assign o_item_kind       = r_fifo[r_rd_ptr].item_kind;
    assign o_payload_byte    = r_fifo[r_rd_ptr].payload_byte;
    assign o_station_address = r_fifo[r_rd_ptr].station_address;
    assign o_function_code   = r_fifo[r_rd_ptr].function_code;
    assign o_payload_count   = r_fifo[r_rd_ptr].payload_count;
    assign o_crc_match       = r_fifo[r_rd_ptr].crc_match;
    assign o_length_status   = r_fifo[r_rd_ptr].length_status;
    assign o_last_of_run     = r_fifo[r_rd_ptr].last_of_run;

endmodule
